// ===== design/timestamped_csv_line_formatter_assert.svh =====
// Assertion macros, sampled on clk and disabled during rst
`ifndef TIMESTAMPED_CSV_LINE_FORMATTER_ASSERT_SVH
`define TIMESTAMPED_CSV_LINE_FORMATTER_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== design/tcf_pkg.sv =====
package tcf_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int NUM_CHANNELS = 8;
  localparam int CHAN_W       = $clog2(NUM_CHANNELS);
  // decimal digits needed for 2^SAMPLE_BITS - 1
  localparam int BCD_DIGITS   = (SAMPLE_BITS * 30103) / 100000 + 1;
  localparam int DIGIT_W      = $clog2(BCD_DIGITS);
  localparam int BIT_CNT_W    = $clog2(SAMPLE_BITS + 1);

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_DOT  = 8'h2E;
  localparam logic [7:0] ASCII_SEMI = 8'h3B;
  localparam logic [7:0] ASCII_NL   = 8'h0A;

  localparam logic [3:0] TIME_LAST  = 4'd9;

  typedef struct packed {
    logic [3:0] min1;
    logic [3:0] min0;
    logic [3:0] sec1;
    logic [3:0] sec0;
    logic [3:0] ms2;
    logic [3:0] ms1;
    logic [3:0] ms0;
  } time_t;

  typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TIME,
    ST_CONV,
    ST_DIGIT,
    ST_SEP
  } state_t;

endpackage

// ===== design/tcf_clock.sv =====
module tcf_clock import tcf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  tick,
  input  logic  clear,
  output time_t tm
);

  time_t tm_next;

  // BCD counter: mmm wraps at 1000, ss at 60, MM at 100
  always_comb begin
    tm_next = tm;
    if (clear) begin
      tm_next = '0;
    end else if (tick) begin
      if (tm.ms0 != 4'd9) begin
        tm_next.ms0 = tm.ms0 + 4'd1;
      end else begin
        tm_next.ms0 = '0;
        if (tm.ms1 != 4'd9) begin
          tm_next.ms1 = tm.ms1 + 4'd1;
        end else begin
          tm_next.ms1 = '0;
          if (tm.ms2 != 4'd9) begin
            tm_next.ms2 = tm.ms2 + 4'd1;
          end else begin
            tm_next.ms2 = '0;
            if (tm.sec0 != 4'd9) begin
              tm_next.sec0 = tm.sec0 + 4'd1;
            end else begin
              tm_next.sec0 = '0;
              if (tm.sec1 != 4'd5) begin
                tm_next.sec1 = tm.sec1 + 4'd1;
              end else begin
                tm_next.sec1 = '0;
                if (tm.min0 != 4'd9) begin
                  tm_next.min0 = tm.min0 + 4'd1;
                end else begin
                  tm_next.min0 = '0;
                  tm_next.min1 = (tm.min1 == 4'd9) ? 4'd0 : tm.min1 + 4'd1;
                end
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tm <= '0;
    end else begin
      tm <= tm_next;
    end
  end

endmodule

// ===== design/tcf_dabble.sv =====
module tcf_dabble import tcf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] din,
  output logic                   done,
  output bcd_t                   digits
);

  logic                   busy;
  logic                   busy_next;
  logic                   done_next;
  logic [BIT_CNT_W-1:0]   cnt;
  logic [BIT_CNT_W-1:0]   cnt_next;
  logic [SAMPLE_BITS-1:0] shreg;
  logic [SAMPLE_BITS-1:0] shreg_next;
  bcd_t                   adj;
  bcd_t                   digits_next;

  // shift-and-add-3, one input bit per cycle, MSB first
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[i] = (digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
    end
  end

  always_comb begin
    busy_next   = busy;
    done_next   = 1'b0;
    cnt_next    = cnt;
    shreg_next  = shreg;
    digits_next = digits;
    if (start) begin
      busy_next   = 1'b1;
      cnt_next    = BIT_CNT_W'(SAMPLE_BITS);
      shreg_next  = din;
      digits_next = '0;
    end else if (busy) begin
      // top bit of the top digit never carries for an in-range sample
      digits_next = {adj[BCD_DIGITS-1][2:0], adj[BCD_DIGITS-2:0], shreg[SAMPLE_BITS-1]};
      shreg_next  = {shreg[SAMPLE_BITS-2:0], 1'b0};
      cnt_next    = cnt - BIT_CNT_W'(1);
      if (cnt == BIT_CNT_W'(1)) begin
        busy_next = 1'b0;
        done_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      busy <= busy_next;
      done <= done_next;
      cnt  <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    shreg  <= shreg_next;
    digits <= digits_next;
  end

endmodule

// ===== design/timestamped_csv_line_formatter.sv =====
// A tick word moves the sequencer to its timestamp state, and each character of a line
// is then offered from the output register. The line length is set by the bit-serial
// binary-to-decimal converter, one sample bit per cycle.
// A clear word zeroes the clock, emitting nothing; a new word is taken once a line is done.
// Synchronous reset: clock to 00.00.000, sequencer idle, output register empty.
module timestamped_csv_line_formatter import tcf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   action,
  input  logic [SAMPLE_BITS-1:0] sample_ch0,
  input  logic [SAMPLE_BITS-1:0] sample_ch1,
  input  logic [SAMPLE_BITS-1:0] sample_ch2,
  input  logic [SAMPLE_BITS-1:0] sample_ch3,
  input  logic [SAMPLE_BITS-1:0] sample_ch4,
  input  logic [SAMPLE_BITS-1:0] sample_ch5,
  input  logic [SAMPLE_BITS-1:0] sample_ch6,
  input  logic [SAMPLE_BITS-1:0] sample_ch7,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             char_byte,
  output logic                   line_end
);

  state_t state;
  state_t state_next;

  logic [3:0]             tindex;
  logic [CHAN_W-1:0]      chan;
  logic [DIGIT_W-1:0]     dindex;
  logic                   started;
  logic [SAMPLE_BITS-1:0] bank [NUM_CHANNELS];

  logic       in_take;
  logic       tick;
  logic       clear;
  logic       emit_ok;
  logic       emit;
  logic [7:0] emit_char;
  logic       emit_last;
  logic       dab_start;
  logic       dab_done;
  logic       dig_show;
  logic       chan_last;
  logic [3:0] dig;
  logic [7:0] tchar;
  time_t      tm;
  bcd_t       digits;

  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign tick      = in_take && !action;
  assign clear     = in_take && action;
  assign emit_ok   = !out_valid || !out_stall;
  assign chan_last = (chan == CHAN_W'(NUM_CHANNELS - 1));
  assign dig       = digits[dindex];
  assign dig_show  = (dig != 4'd0) || started || (dindex == '0);

  tcf_clock u_clock (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick),
    .clear (clear),
    .tm    (tm)
  );

  tcf_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .start  (dab_start),
    .din    (bank[0]),
    .done   (dab_done),
    .digits (digits)
  );

  // timestamp field MM.SS.mmm;
  always_comb begin
    case (tindex)
      4'd0:    tchar = ASCII_ZERO | {4'h0, tm.min1};
      4'd1:    tchar = ASCII_ZERO | {4'h0, tm.min0};
      4'd2:    tchar = ASCII_DOT;
      4'd3:    tchar = ASCII_ZERO | {4'h0, tm.sec1};
      4'd4:    tchar = ASCII_ZERO | {4'h0, tm.sec0};
      4'd5:    tchar = ASCII_DOT;
      4'd6:    tchar = ASCII_ZERO | {4'h0, tm.ms2};
      4'd7:    tchar = ASCII_ZERO | {4'h0, tm.ms1};
      4'd8:    tchar = ASCII_ZERO | {4'h0, tm.ms0};
      default: tchar = ASCII_SEMI;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (tick) state_next = ST_TIME;
      end
      ST_TIME: begin
        if (emit_ok && tindex == TIME_LAST) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (dab_done) state_next = ST_DIGIT;
      end
      ST_DIGIT: begin
        if ((!dig_show || emit_ok) && dindex == '0) state_next = ST_SEP;
      end
      ST_SEP: begin
        if (emit_ok) state_next = chan_last ? ST_IDLE : ST_CONV;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    emit_char = ASCII_SEMI;
    emit_last = 1'b0;
    dab_start = 1'b0;
    case (state)
      ST_TIME: begin
        emit      = emit_ok;
        emit_char = tchar;
        dab_start = emit_ok && (tindex == TIME_LAST);
      end
      ST_DIGIT: begin
        emit      = emit_ok && dig_show;
        emit_char = ASCII_ZERO | {4'h0, dig};
      end
      ST_SEP: begin
        emit      = emit_ok;
        emit_char = chan_last ? ASCII_NL : ASCII_SEMI;
        emit_last = chan_last;
        dab_start = emit_ok && !chan_last;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      tindex    <= '0;
      chan      <= '0;
      dindex    <= '0;
      started   <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= emit || (out_valid && out_stall);
      if (tick) begin
        tindex <= '0;
        chan   <= '0;
      end else if (state == ST_TIME && emit_ok && tindex != TIME_LAST) begin
        tindex <= tindex + 4'd1;
      end else if (state == ST_SEP && emit_ok && !chan_last) begin
        chan <= chan + CHAN_W'(1);
      end
      if (state == ST_CONV) begin
        dindex  <= DIGIT_W'(BCD_DIGITS - 1);
        started <= 1'b0;
      end else if (state == ST_DIGIT && (!dig_show || emit_ok)) begin
        if (dindex != '0) dindex <= dindex - DIGIT_W'(1);
        if (dig_show) started <= 1'b1;
      end
    end
  end

  // sample bank: channel 0 sits at the converter input, shifted on each start
  always_ff @(posedge clk) begin
    if (tick) begin
      bank[0] <= sample_ch0;
      bank[1] <= sample_ch1;
      bank[2] <= sample_ch2;
      bank[3] <= sample_ch3;
      bank[4] <= sample_ch4;
      bank[5] <= sample_ch5;
      bank[6] <= sample_ch6;
      bank[7] <= sample_ch7;
    end else if (dab_start) begin
      for (int i = 0; i < NUM_CHANNELS - 1; i++) begin
        bank[i] <= bank[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_byte <= emit_char;
      line_end  <= emit_last;
    end
  end

`include "timestamped_csv_line_formatter_assert.svh"

  `ASSERT_NEXT(a_tick_starts_line, tick, state == ST_TIME, "tick did not start a line")
  `ASSERT_IMPLY(a_done_in_conv, dab_done, state == ST_CONV, "converter finished out of turn")
  `ASSERT_IMPLY(a_line_end_nl, out_valid && line_end, char_byte == ASCII_NL, "bad line end")
  `ASSERT_ALWAYS(a_clock_bcd, tm.ms0 <= 4'd9 && tm.sec1 <= 4'd5 && tm.min1 <= 4'd9, "bad BCD")

endmodule
